// ===== design/mbps_pkg.sv =====
// Shared constants and types for the masked byte pattern search block.
// Holds configuration register codes, port widths and parameter defaults.
// No dependencies.
`default_nettype none

package mbps_pkg;

    // Parameter defaults
    localparam int PATTERN_BYTES_DEFAULT = 16;
    localparam int POSITION_BITS_DEFAULT = 32;

    // Configuration port widths
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    // Width of the pattern length register (0 to 31 can be written)
    localparam int LENGTH_BITS = 5;

    // Result queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_MASK_LOW       = 3'd2,
        CFG_MASK_HIGH      = 3'd3,
        CFG_PATTERN_LENGTH = 3'd4,
        CFG_MASK_ON        = 3'd5
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== design/mbps_front.sv =====
// Front part of the masked byte pattern search: configuration registers,
// byte history window, byte counter and the parallel lane compare.
// Depends on mbps_pkg.
`default_nettype none

module mbps_front #(
    parameter int PATTERN_BYTES = mbps_pkg::PATTERN_BYTES_DEFAULT,
    parameter int POSITION_BITS = mbps_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration writes
    input  wire logic                                cfg_valid,
    input  wire logic [mbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // Range byte channel
    input  wire logic                                range_valid,
    output logic                                     range_stall,
    input  wire logic [7:0]                          range_byte,
    input  wire logic                                range_end,
    // Result queue write side
    input  wire logic                                queue_full,
    output logic                                     push,
    output logic                                     push_found,
    output logic [POSITION_BITS-1:0]                 push_position
);

    localparam int LEN_BITS  = mbps_pkg::LENGTH_BITS;
    localparam int WIN_DEPTH = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1;
    localparam logic [LEN_BITS-1:0] LEN_CAP = LEN_BITS'(PATTERN_BYTES);
    localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;

    // Configuration registers
    logic [63:0]         pattern_low_reg;
    logic [63:0]         pattern_high_reg;
    logic [63:0]         mask_low_reg;
    logic [63:0]         mask_high_reg;
    logic [LEN_BITS-1:0] pattern_length_reg;
    logic                mask_on_reg;

    // Per-range state
    logic [7:0]               window_reg [WIN_DEPTH];
    logic [POSITION_BITS-1:0] count_reg;
    logic [POSITION_BITS-1:0] count_next;
    logic                     match_done_reg;
    logic                     match_done_next;

    logic                     accept;
    logic [LEN_BITS-1:0]      len_eff;
    logic [POSITION_BITS-1:0] len_ext;
    logic [127:0]             pattern_all;
    logic [127:0]             mask_all;
    logic [7:0]               hist [PATTERN_BYTES];
    logic [7:0]               cand [PATTERN_BYTES];
    logic [7:0]               lane_mask [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] lane_ok;
    logic                     hit;
    logic [POSITION_BITS-1:0] hit_position;

    // Hold off new bytes while the result queue has no room
    assign range_stall = queue_full;
    assign accept      = range_valid && !range_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            mask_low_reg       <= '1;
            mask_high_reg      <= '1;
            pattern_length_reg <= LEN_BITS'(1);
            mask_on_reg        <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mbps_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                mbps_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                mbps_pkg::CFG_MASK_LOW:       mask_low_reg       <= cfg_data;
                mbps_pkg::CFG_MASK_HIGH:      mask_high_reg      <= cfg_data;
                mbps_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_BITS-1:0];
                mbps_pkg::CFG_MASK_ON:        mask_on_reg        <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    // Clamp the length to the lanes that exist
    assign len_eff     = (pattern_length_reg > LEN_CAP) ? LEN_CAP : pattern_length_reg;
    assign len_ext     = {{(POSITION_BITS-LEN_BITS){1'b0}}, len_eff};
    assign pattern_all = {pattern_high_reg, pattern_low_reg};
    assign mask_all    = {mask_high_reg, mask_low_reg};

    // Saturating byte count including the current byte
    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // Compare every pattern lane in parallel; lane i sees the byte len-1-i steps back
    always_comb
    begin
        for (int k = 0; k < PATTERN_BYTES; k++)
        begin
            if (k == 0)
                hist[k] = range_byte;
            else
                hist[k] = window_reg[k-1];
        end
        for (int i = 0; i < PATTERN_BYTES; i++)
        begin
            cand[i]      = '0;
            lane_mask[i] = mask_on_reg ? mask_all[8*i +: 8] : 8'hFF;
            for (int k = 0; k < PATTERN_BYTES; k++)
            begin
                if (int'(len_eff) == i + k + 1)
                    cand[i] = hist[k];
            end
            lane_ok[i] = (i >= int'(len_eff))
                      || ((cand[i] & lane_mask[i]) == pattern_all[8*i +: 8]);
        end
    end

    // Only bytes of the current range count: the window is read no deeper than count
    assign hit          = (&lane_ok) && (count_next >= len_ext);
    assign hit_position = (len_eff == '0) ? '0 : count_next - len_ext;

    // Emit at the first match, or at the range end when nothing matched
    assign push          = accept && !match_done_reg && (hit || range_end);
    assign push_found    = hit;
    assign push_position = hit ? hit_position : count_next;

    assign match_done_next = match_done_reg || hit;

    // Advance the counter and match flag; drop them at the range end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            match_done_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (range_end)
            begin
                count_reg      <= '0;
                match_done_reg <= 1'b0;
            end
            else
            begin
                count_reg      <= count_next;
                match_done_reg <= match_done_next;
            end
        end
    end

    // Shift the byte history; stale bytes are never compared thanks to the count check
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg[0] <= range_byte;
            for (int k = 1; k < WIN_DEPTH; k++)
                window_reg[k] <= window_reg[k-1];
        end
    end

endmodule

`default_nettype wire

// ===== design/mbps_queue.sv =====
// Small result queue that decouples the compare front from the output stage.
// Holds found and position of pending results. Depends on mbps_pkg.
`default_nettype none

module mbps_queue #(
    parameter int WIDTH = mbps_pkg::POSITION_BITS_DEFAULT + 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int DEPTH    = mbps_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store the incoming result
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== design/mbps_back.sv =====
// Output stage of the masked byte pattern search: drains the result queue
// into a registered result beat. Depends on mbps_pkg.
`default_nettype none

module mbps_back #(
    parameter int POSITION_BITS = mbps_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     queue_empty,
    input  wire logic [POSITION_BITS:0]   queue_data,
    output logic                          pop,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic                          found,
    output logic [POSITION_BITS-1:0]      position
);

    logic                     valid_reg;
    logic                     found_reg;
    logic [POSITION_BITS-1:0] position_reg;
    logic                     load;

    // Take a new beat when the output register is free or being taken
    assign load = !valid_reg || !result_stall;
    assign pop  = load && !queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= !queue_empty;
    end

    // Hold the payload while stalled
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            found_reg    <= queue_data[POSITION_BITS];
            position_reg <= queue_data[POSITION_BITS-1:0];
        end
    end

    assign result_valid = valid_reg;
    assign found        = found_reg;
    assign position     = position_reg;

endmodule

`default_nettype wire

// ===== design/masked_byte_pattern_search.sv =====
// Masked byte pattern search, top level.
// Instantiates mbps_front, mbps_queue and mbps_back; depends on mbps_pkg.
//
// The block takes one range byte per cycle and compares all pattern lanes at
// once against a shift window of the last PATTERN_BYTES-1 bytes, so a byte
// can be accepted every cycle. A range gives at most one result beat: found 1
// with the start offset at the first match (later bytes of that range are
// swallowed), or found 0 with the range length when the range ends without a
// match. Results pass through a four-entry queue and then an output register;
// range_stall rises only when that queue is full. Configuration writes are
// always ready and should be made while no range is in progress.
`default_nettype none

module masked_byte_pattern_search #(
    parameter int PATTERN_BYTES = mbps_pkg::PATTERN_BYTES_DEFAULT,
    parameter int POSITION_BITS = mbps_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // Range byte channel
    input  wire logic                                range_valid,
    output logic                                     range_stall,
    input  wire logic [7:0]                          range_byte,
    input  wire logic                                range_end,
    // Result channel
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic                                     found,
    output logic [POSITION_BITS-1:0]                 position
);

    logic                     push;
    logic                     push_found;
    logic [POSITION_BITS-1:0] push_position;
    logic                     pop;
    logic                     queue_full;
    logic                     queue_empty;
    logic [POSITION_BITS:0]   queue_data;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;

    mbps_front #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .range_valid   (range_valid),
        .range_stall   (range_stall),
        .range_byte    (range_byte),
        .range_end     (range_end),
        .queue_full    (queue_full),
        .push          (push),
        .push_found    (push_found),
        .push_position (push_position)
    );

    mbps_queue #(
        .WIDTH (POSITION_BITS + 1)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({push_found, push_position}),
        .pop     (pop),
        .rd_data (queue_data),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    mbps_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .queue_data   (queue_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .position     (position)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for masked_byte_pattern_search: streams byte ranges,
// predicts each search result and compares it with the result beats.
// Depends on mbps_pkg and the masked_byte_pattern_search RTL.
module tb_top;

    localparam int PAT_BYTES     = mbps_pkg::PATTERN_BYTES_DEFAULT;
    localparam int POS_BITS      = mbps_pkg::POSITION_BITS_DEFAULT;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 12;
    localparam int PHASE_BYTES   = 40;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] position;
    } search_result_t;

    // Track the search state and the results still owed by the block
    class match_tracker;
        logic [63:0]                      pat_lo;
        logic [63:0]                      pat_hi;
        logic [63:0]                      msk_lo;
        logic [63:0]                      msk_hi;
        logic [mbps_pkg::LENGTH_BITS-1:0] pat_len;
        logic                             mask_en;
        logic [7:0]                       window [PAT_BYTES-1];
        logic [POS_BITS-1:0]              count;
        logic                             done;
        search_result_t                   awaited [$];
        int                               errors;
        int                               shown;

        function new();
            pat_lo  = '0;
            pat_hi  = '0;
            msk_lo  = '1;
            msk_hi  = '1;
            pat_len = 1;
            mask_en = 1'b0;
            errors  = 0;
            shown   = 0;
            clear_range();
        endfunction

        function void clear_range();
            foreach (window[i])
                window[i] = '0;
            count = '0;
            done  = 1'b0;
        endfunction

        function logic [7:0] pattern_byte(int i);
            return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
        endfunction

        function logic [7:0] mask_byte(int i);
            return (i < 8) ? msk_lo[8*i +: 8] : msk_hi[8*(i-8) +: 8];
        endfunction

        // Lengths above the lane count behave as the full pattern
        function int active_length();
            return (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
        endfunction

        function void write_reg(mbps_pkg::cfg_reg_t idx, logic [63:0] data);
            unique case (idx)
                mbps_pkg::CFG_PATTERN_LOW:    pat_lo  = data;
                mbps_pkg::CFG_PATTERN_HIGH:   pat_hi  = data;
                mbps_pkg::CFG_MASK_LOW:       msk_lo  = data;
                mbps_pkg::CFG_MASK_HIGH:      msk_hi  = data;
                mbps_pkg::CFG_PATTERN_LENGTH: pat_len = data[mbps_pkg::LENGTH_BITS-1:0];
                mbps_pkg::CFG_MASK_ON:        mask_en = data[0];
                default: ;
            endcase
        endfunction

        // Advance the search by one accepted byte and queue any result it causes
        function void note_byte(logic [7:0] b, logic last);
            int                  len;
            logic [POS_BITS-1:0] nxt;
            logic                hit;
            logic [7:0]          x;
            len = active_length();
            nxt = (count == '1) ? count : count + 1'b1;
            if (!done)
            begin
                hit = (nxt >= len);
                for (int i = 0; i < len; i++)
                begin
                    if (i == len - 1)
                        x = b;
                    else
                        x = window[len - 2 - i];
                    if (mask_en)
                        x = x & mask_byte(i);
                    if (x != pattern_byte(i))
                        hit = 1'b0;
                end
                if (hit)
                begin
                    awaited.push_back(search_result_t'{found: 1'b1,
                                      position: (len == 0) ? '0 : nxt - len});
                    done = 1'b1;
                end
                else if (last)
                begin
                    awaited.push_back(search_result_t'{found: 1'b0, position: nxt});
                end
            end
            for (int j = PAT_BYTES - 2; j > 0; j--)
                window[j] = window[j-1];
            window[0] = b;
            count = nxt;
            if (last)
                clear_range();
        endfunction

        function void flag(string msg);
            errors++;
            if (shown < 10)
            begin
                shown++;
                $display("%s", msg);
            end
        endfunction

        // Compare one result beat with the oldest expected result
        function void check_beat(logic f, logic [POS_BITS-1:0] p);
            search_result_t want;
            if (awaited.size() == 0)
            begin
                flag($sformatf("unexpected result beat: found=%0d position=%0d", f, p));
            end
            else
            begin
                want = awaited.pop_front();
                if (want.found !== f || want.position !== p)
                    flag($sformatf({"result mismatch: expected found=%0d position=%0d,",
                                    " got found=%0d position=%0d"},
                                   want.found, want.position, f, p));
            end
        endfunction
    endclass

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                cfg_valid    = 1'b0;
    logic                                cfg_ready;
    logic [mbps_pkg::CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [mbps_pkg::CFG_DATA_BITS-1:0]  cfg_data     = '0;
    logic                                range_valid  = 1'b0;
    logic                                range_stall;
    logic [7:0]                          range_byte   = '0;
    logic                                range_end    = 1'b0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    logic                                found;
    logic [POS_BITS-1:0]                 position;

    match_tracker tracker;
    int           send_gap_pct   = 0;
    int           recv_stall_pct = 0;
    int           cycle_count    = 0;

    masked_byte_pattern_search i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .range_valid  (range_valid),
        .range_stall  (range_stall),
        .range_byte   (range_byte),
        .range_end    (range_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .position     (position)
    );

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Check each accepted result beat, then pick the next stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                tracker.check_beat(found, position);
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Write all six registers; the block must be idle
    task automatic load_config(input logic [63:0] p_lo, input logic [63:0] p_hi,
                               input logic [63:0] m_lo, input logic [63:0] m_hi,
                               input logic [63:0] len_word, input logic [63:0] on_word);
        mbps_pkg::cfg_reg_t order [6];
        logic [63:0]        value [6];
        order = '{mbps_pkg::CFG_PATTERN_LOW, mbps_pkg::CFG_PATTERN_HIGH,
                  mbps_pkg::CFG_MASK_LOW, mbps_pkg::CFG_MASK_HIGH,
                  mbps_pkg::CFG_PATTERN_LENGTH, mbps_pkg::CFG_MASK_ON};
        value = '{p_lo, p_hi, m_lo, m_hi, len_word, on_word};
        for (int k = 0; k < 6; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[k];
            cfg_data  <= value[k];
            do @(posedge clk); while (!cfg_ready);
            tracker.write_reg(order[k], value[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Offer one byte beat, after a random gap, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            range_valid <= 1'b0;
            @(posedge clk);
        end
        range_valid <= 1'b1;
        range_byte  <= b;
        range_end   <= last;
        do @(posedge clk); while (range_stall);
        tracker.note_byte(b, last);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty
    task automatic settle();
        range_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random phase: pick settings, then stream ranges that mostly hold the pattern
    task automatic run_phase(input int phase);
        logic [63:0] p_lo;
        logic [63:0] p_hi;
        logic [63:0] m_lo;
        logic [63:0] m_hi;
        logic [63:0] len_word;
        logic [63:0] on_word;
        logic        on;
        logic        alpha;
        logic [7:0]  b;
        logic [7:0]  bytes [$];
        int          plen;
        int          n;
        int          at;
        int          sent;
        alpha = ($urandom_range(1) == 1);
        m_lo  = {$urandom, $urandom};
        m_hi  = {$urandom, $urandom};
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            b = alpha ? (($urandom_range(1) == 1) ? 8'h61 : 8'h62) : 8'($urandom);
            if (i < 8)
                p_lo[8*i +: 8] = b;
            else
                p_hi[8*(i-8) +: 8] = b;
        end
        on   = ($urandom_range(1) == 1);
        plen = $urandom_range(2, 6);
        unique case (phase % 6)
            0:
            begin
                plen = 1;
                m_lo = '1;
                m_hi = '1;
            end
            1:
            begin
                plen = PAT_BYTES;
                if (phase < 6)
                    {p_lo, p_hi} = '0;
                else
                    {p_lo, p_hi} = '1;
            end
            2: plen = 0;
            3: plen = $urandom_range(PAT_BYTES + 1, 31);
            4:
            begin
                on = 1'b1;
                if (phase < 6)
                begin
                    m_lo = '0;
                    m_hi = '0;
                end
                else
                    plen = $urandom_range(9, PAT_BYTES);
            end
            default: ;
        endcase
        // Keep the pattern inside its mask most of the time so it can match
        if (on && $urandom_range(9) != 0)
        begin
            p_lo = p_lo & m_lo;
            p_hi = p_hi & m_hi;
        end
        len_word      = {$urandom, $urandom};
        len_word[4:0] = plen[4:0];
        on_word       = {$urandom, $urandom};
        on_word[0]    = on;
        load_config(p_lo, p_hi, m_lo, m_hi, len_word, on_word);

        plen = tracker.active_length();
        sent = 0;
        while (sent < PHASE_BYTES)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, plen + 8);
            bytes.delete();
            for (int i = 0; i < n; i++)
                bytes.push_back((alpha && $urandom_range(7) != 0) ?
                                (($urandom_range(1) == 1) ? 8'h61 : 8'h62) : 8'($urandom));
            // Plant the pattern, with free bits outside the mask, sometimes one bit off
            if ($urandom_range(3) != 0 && plen != 0 && plen <= n)
            begin
                at = $urandom_range(0, n - plen);
                for (int i = 0; i < plen; i++)
                begin
                    b = tracker.pattern_byte(i);
                    if (tracker.mask_en)
                        b = b | (8'($urandom) & ~tracker.mask_byte(i));
                    bytes[at + i] = b;
                end
                if ($urandom_range(3) == 0)
                    bytes[at + $urandom_range(0, plen - 1)] ^= 8'(1 << $urandom_range(0, 7));
            end
            for (int i = 0; i < n; i++)
                send_byte(bytes[i], i == n - 1);
            sent += n;
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: sender idles lightly, receiver stalls heavily
        send_gap_pct   = 21;
        recv_stall_pct = 88;

        // Reset settings: one-byte pattern 00, exact compare
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        settle();

        // Pattern 00 FF 80: short range, match on last byte, bytes after a match
        load_config(64'hFFFF_FFFF_FF80_FF00, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3, 64'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        // Empty pattern matches at the first byte
        load_config(64'h0, 64'h0, 64'h0, 64'h0, 64'd0, 64'd0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // Masked compare: lane 0 matches under its mask, lane 1 lies outside its mask
        load_config(64'h0000_0000_0000_F005, 64'h0, 64'h0000_0000_0000_0F0F, 64'h0,
                    64'd1, 64'd1);
        send_byte(8'hA5, 1'b1);
        settle();
        load_config(64'h0000_0000_0000_F005, 64'h0, 64'h0000_0000_0000_0F0F, 64'h0,
                    64'd2, 64'd1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hF0, 1'b1);
        settle();

        // Random phases: sender light, then receiver light, then no idling
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 4)
            begin
                send_gap_pct   = 21;
                recv_stall_pct = 88;
            end
            else if (ph < 8)
            begin
                send_gap_pct   = 88;
                recv_stall_pct = 21;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            run_phase(ph);
            settle();
        end

        if (tracker.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mbps_pkg.sv
design/mbps_front.sv
design/mbps_queue.sv
design/mbps_back.sv
design/masked_byte_pattern_search.sv
sim/tb_top.sv
